[rtl/core/stereo_echo_mixer_assert.svh]
// assertion macros used by smix_back
`ifndef STEREO_ECHO_MIXER_ASSERT_SVH
`define STEREO_ECHO_MIXER_ASSERT_SVH

// clocked check, quiet while reset is asserted
`define SMIX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check that also holds during reset
`define SMIX_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/core/smix_pkg.sv]
`default_nettype none

package smix_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 12;

  localparam logic [15:0] DELAY_RESET = 16'd1;
  localparam logic [15:0] GAIN_RESET  = 16'd4096;

  // frame queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // configuration register indexes
  typedef enum logic {
    CFG_ECHO_DELAY = 1'b0,
    CFG_ECHO_GAIN  = 1'b1
  } cfg_idx_e;

  // where the echo term of a frame comes from
  typedef enum logic [1:0] {
    MIX_NONE = 2'b00,
    MIX_SELF = 2'b01,
    MIX_LINE = 2'b10
  } mix_cls_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    mix_cls_e                   cls;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

endpackage

`default_nettype wire

[rtl/core/smix_if.sv]
`default_nettype none

// stereo frame going into the block
interface smix_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

// mixed stereo frame coming out of the block
interface smix_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

[rtl/core/smix_front.sv]
`default_nettype none

module smix_front #(
  parameter int unsigned HISTORY_DEPTH = 65536
) (
  smix_in_if.sink              in_i,
  input  logic [15:0]          echo_delay_i,
  input  smix_pkg::q_status_t  q_stat_i,
  output logic                 push_o,
  output smix_pkg::q_entry_t   entry_o
);
  import smix_pkg::*;

  // take a beat whenever the queue has room
  assign in_i.ready = !q_stat_i.full;
  assign push_o     = in_i.valid && !q_stat_i.full;

  // classify the echo source from the current delay
  always_comb begin
    entry_o.left  = in_i.left_sample;
    entry_o.right = in_i.right_sample;
    if (echo_delay_i == '0) begin
      entry_o.cls = MIX_SELF;
    end else if (32'(echo_delay_i) < 32'(HISTORY_DEPTH)) begin
      entry_o.cls = MIX_LINE;
    end else begin
      entry_o.cls = MIX_NONE;
    end
  end

endmodule

`default_nettype wire

[rtl/core/smix_fifo.sv]
`default_nettype none

module smix_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  smix_pkg::q_entry_t  entry_i,
  input  logic                pop_i,
  output smix_pkg::q_status_t stat_o,
  output smix_pkg::q_entry_t  entry_o
);
  import smix_pkg::*;

  q_entry_t        slot_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_AW:0]   count_q;

  assign stat_o.full      = (count_q == (Q_AW+1)'(Q_DEPTH));
  assign stat_o.not_empty = (count_q != '0);
  assign entry_o          = slot_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + Q_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + Q_AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (Q_AW+1)'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - (Q_AW+1)'(1);
      end
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/smix_back.sv]
`default_nettype none

`include "stereo_echo_mixer_assert.svh"

module smix_back #(
  parameter int unsigned HISTORY_DEPTH = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         echo_delay_i,
  input  logic [15:0]         echo_gain_i,
  input  smix_pkg::q_status_t q_stat_i,
  input  smix_pkg::q_entry_t  entry_i,
  output logic                pop_o,
  smix_out_if.source          out_o
);
  import smix_pkg::*;

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = ((AW > 16) ? AW : 16) + 1;
  localparam logic signed [32:0] ROUND_BIAS = 33'((1 << GAIN_FRAC) - 1);

  // scale the product toward zero, add the dry sample, clamp to 16 bits
  function automatic logic signed [15:0] mix_sat(input logic signed [15:0] cur,
                                                 input logic signed [32:0] prod);
    logic signed [32:0] biased;
    logic signed [20:0] scaled;
    logic signed [21:0] sum;
    biased = prod[32] ? (prod + ROUND_BIAS) : prod;
    scaled = 21'(biased >>> GAIN_FRAC);
    sum    = 22'(cur) + 22'(scaled);
    if (sum > 22'sd32767) begin
      return 16'sh7fff;
    end else if (sum < -22'sd32768) begin
      return 16'sh8000;
    end
    return 16'(sum);
  endfunction

  logic signed [15:0] mem_l [HISTORY_DEPTH];
  logic signed [15:0] mem_r [HISTORY_DEPTH];

  logic [AW-1:0] pos_q;
  logic          wrapped_q;

  logic                 s1_valid_q, s2_valid_q, out_valid_q;
  q_entry_t             s1_ent_q;
  logic                 s1_hit_q;
  logic signed [15:0]   rd_l_q, rd_r_q;
  logic signed [15:0]   s2_left_q, s2_right_q;
  mix_cls_e             s2_cls_q;
  logic signed [32:0]   prod_l_q, prod_r_q;
  logic signed [15:0]   out_left_q, out_right_q;

  logic                 en, pop;
  logic [CW-1:0]        pos_w, dly_w, diff;
  logic [AW-1:0]        rd_addr;
  logic                 hit;
  logic signed [16:0]   gain_s;
  logic signed [15:0]   past_l, past_r;
  logic signed [32:0]   prod_l_d, prod_r_d;

  // whole back pipeline moves when the output register can take a beat
  assign en    = !out_valid_q || out_o.ready;
  assign pop   = q_stat_i.not_empty && en;
  assign pop_o = pop;

  // read address behind the write slot, wrapping over the line
  always_comb begin
    pos_w = CW'(pos_q);
    dly_w = CW'(echo_delay_i);
    if (pos_w >= dly_w) begin
      diff = pos_w - dly_w;
    end else begin
      diff = pos_w + CW'(HISTORY_DEPTH) - dly_w;
    end
    rd_addr = diff[AW-1:0];
    // slots below the write slot are filled until the first wrap
    hit = wrapped_q || (pos_w >= dly_w);
  end

  // write slot and fill mark
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      wrapped_q <= 1'b0;
    end else if (pop) begin
      if (pos_q == AW'(HISTORY_DEPTH - 1)) begin
        pos_q     <= '0;
        wrapped_q <= 1'b1;
      end else begin
        pos_q <= pos_q + AW'(1);
      end
    end
  end

  // delay line: one write and one registered read per frame
  always_ff @(posedge clk_i) begin
    if (pop) begin
      mem_l[pos_q] <= entry_i.left;
      mem_r[pos_q] <= entry_i.right;
      rd_l_q       <= mem_l[rd_addr];
      rd_r_q       <= mem_r[rd_addr];
      s1_ent_q     <= entry_i;
      s1_hit_q     <= hit;
    end
  end

  // pick the echo sample and multiply by the gain
  assign gain_s = $signed({1'b0, echo_gain_i});

  always_comb begin
    case (s1_ent_q.cls)
      MIX_SELF: begin
        past_l = s1_ent_q.left;
        past_r = s1_ent_q.right;
      end
      MIX_LINE: begin
        past_l = s1_hit_q ? rd_l_q : '0;
        past_r = s1_hit_q ? rd_r_q : '0;
      end
      default: begin
        past_l = '0;
        past_r = '0;
      end
    endcase
    prod_l_d = past_l * gain_s;
    prod_r_d = past_r * gain_s;
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_left_q   <= s1_ent_q.left;
      s2_right_q  <= s1_ent_q.right;
      s2_cls_q    <= s1_ent_q.cls;
      prod_l_q    <= prod_l_d;
      prod_r_q    <= prod_r_d;
      out_left_q  <= mix_sat(s2_left_q, prod_l_q);
      out_right_q <= mix_sat(s2_right_q, prod_r_q);
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= pop;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.left_out  = out_left_q;
  assign out_o.right_out = out_right_q;

  // checks
  `SMIX_ASSERT(a_out_from_pipe, $rose(out_valid_q) |-> $past(s2_valid_q), "output beat without a frame behind it")
  `SMIX_ASSERT(a_pos_step, (pop && (pos_q != AW'(HISTORY_DEPTH - 1))) |=> (pos_q == $past(pos_q) + AW'(1)), "write slot skipped")
  `SMIX_ASSERT(a_dry_pass, (en && s2_valid_q && (s2_cls_q == MIX_NONE)) |=> ((out_left_q == $past(s2_left_q)) && (out_right_q == $past(s2_right_q))), "frame without echo was altered")
  `SMIX_ASSERT_RST(a_reset_idle, !rst_ni |=> (!out_valid_q && !s1_valid_q && !s2_valid_q), "pipeline busy during reset")

endmodule

`default_nettype wire

[rtl/core/stereo_echo_mixer.sv]
// channel   dir  width  contents
// in_i      in   2x16   left_sample, right_sample (signed)
// out_o     out  2x16   left_out, right_out (signed, saturated)
// cfg       in   1+1+16 cfg_we_i, cfg_idx_i, cfg_wdata_i (echo_delay, echo_gain)
//
// one frame per cycle sustained while out_o is ready; set by the single read/write port pair of the delay line
// an input beat passes the frame queue, the delay-line read, product and output registers
// reset empties the pipeline; the delay line reads as zero through a fill mark, no clearing pass
// a stall on out_o freezes the back pipeline while the four-frame queue keeps taking beats until full
`default_nettype none

module stereo_echo_mixer #(
  parameter int unsigned HISTORY_DEPTH = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  smix_in_if.sink            in_i,
  smix_out_if.source         out_o,
  input  logic               cfg_we_i,
  input  smix_pkg::cfg_idx_e cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);
  import smix_pkg::*;

  logic [15:0] echo_delay_q;
  logic [15:0] echo_gain_q;
  q_status_t   q_stat;
  q_entry_t    push_entry, pop_entry;
  logic        push, pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_delay_q <= DELAY_RESET;
      echo_gain_q  <= GAIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ECHO_DELAY: echo_delay_q <= cfg_wdata_i;
        CFG_ECHO_GAIN:  echo_gain_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // accept and classify
  smix_front #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_front (
    .in_i         (in_i),
    .echo_delay_i (echo_delay_q),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  // frame queue
  smix_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .stat_o  (q_stat),
    .entry_o (pop_entry)
  );

  // delay line, multiply and mix
  smix_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .echo_delay_i (echo_delay_q),
    .echo_gain_i  (echo_gain_q),
    .q_stat_i     (q_stat),
    .entry_i      (pop_entry),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

[tb/tb_stereo_echo_mixer.sv]
`default_nettype none

module tb_stereo_echo_mixer;
  import smix_pkg::*;

  // short delay line so wrap-around and out-of-line delays are reachable
  localparam int unsigned HIST_DEPTH = 128;
  localparam int unsigned DIR_N      = 16;
  localparam int unsigned MAX_LINES  = 40;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } mix_frame_t;

  typedef struct packed {
    bit                 set_cfg;
    logic [15:0]        delay;
    logic [15:0]        gain;
    logic signed [15:0] left;
    logic signed [15:0] right;
    bit                 known;
    logic signed [15:0] want_left;
    logic signed [15:0] want_right;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  cfg_idx_e    cfg_idx;
  logic [15:0] cfg_wdata;

  smix_in_if  in_if ();
  smix_out_if out_if ();

  stereo_echo_mixer #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // predictor state
  logic [15:0] left_line  [HIST_DEPTH];
  logic [15:0] right_line [HIST_DEPTH];
  int unsigned line_wr_pos;
  logic [15:0] echo_delay_q;
  logic [15:0] echo_gain_q;

  mix_frame_t  mix_expected [$];
  int unsigned err_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  dir_row_t    dir_rows [DIR_N];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #3200000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic signed [15:0] got,
                                 input logic signed [15:0] want);
    if (err_count < MAX_LINES) begin
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    end
    err_count++;
  endtask

  // one channel: current plus truncated scaled echo, saturated
  function automatic logic signed [15:0] mix_sample(input logic signed [15:0] cur,
                                                    input logic signed [15:0] past,
                                                    input bit echo,
                                                    input logic [15:0] gain);
    longint sum;
    sum = cur;
    if (echo) begin
      sum += (longint'(past) * longint'(gain)) / 4096;
    end
    if (sum > 32767) begin
      sum = 32767;
    end else if (sum < -32768) begin
      sum = -32768;
    end
    return sum[15:0];
  endfunction

  // mix one frame and store it in the delay line
  function automatic mix_frame_t predict_mix(input logic signed [15:0] l,
                                             input logic signed [15:0] r);
    mix_frame_t         res;
    logic signed [15:0] l_past;
    logic signed [15:0] r_past;
    bit                 echo;
    int unsigned        rd;
    l_past = '0;
    r_past = '0;
    echo   = 1'b0;
    if (echo_delay_q == 16'd0) begin
      l_past = l;
      r_past = r;
      echo   = 1'b1;
    end else if (int'(echo_delay_q) < HIST_DEPTH) begin
      rd = (line_wr_pos >= echo_delay_q) ? line_wr_pos - echo_delay_q
                                         : line_wr_pos + HIST_DEPTH - echo_delay_q;
      l_past = left_line[rd];
      r_past = right_line[rd];
      echo   = 1'b1;
    end
    res.left  = mix_sample(l, l_past, echo, echo_gain_q);
    res.right = mix_sample(r, r_past, echo, echo_gain_q);
    left_line[line_wr_pos]  = l;
    right_line[line_wr_pos] = r;
    line_wr_pos = (line_wr_pos == HIST_DEPTH - 1) ? 0 : line_wr_pos + 1;
    return res;
  endfunction

  // register write, issued at a falling edge while idle
  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
    if (idx == CFG_ECHO_DELAY) begin
      echo_delay_q = value;
    end else begin
      echo_gain_q = value;
    end
  endtask

  // stop sending, wait for every pending frame, then let the pipeline settle
  task automatic drain_pipe();
    in_if.valid <= 1'b0;
    while (mix_expected.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // drive one input beat; entered and left at a falling edge
  task automatic send_frame(input logic signed [15:0] l, input logic signed [15:0] r,
                            input bit known, input logic signed [15:0] want_l,
                            input logic signed [15:0] want_r);
    mix_frame_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.left_sample  <= l;
    in_if.right_sample <= r;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pred = predict_mix(l, r);
    if (known) begin
      pred.left  = want_l;
      pred.right = want_r;
    end
    mix_expected.push_back(pred);
    @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_sample();
    logic [15:0] v;
    case ($urandom_range(9))
      0:       v = 16'h7FFF;
      1:       v = 16'h8000;
      2:       v = 16'($urandom_range(200)) - 16'd100;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [15:0] rand_delay();
    logic [15:0] v;
    case ($urandom_range(15))
      0:       v = 16'd0;
      1:       v = 16'(HIST_DEPTH - 1);
      2:       v = 16'($urandom_range(65535, HIST_DEPTH));
      3:       v = 16'hFFFF;
      4:       v = 16'd1;
      default: v = 16'($urandom_range(HIST_DEPTH - 1, 1));
    endcase
    return v;
  endfunction

  function automatic logic [15:0] rand_gain();
    logic [15:0] v;
    case ($urandom_range(7))
      0:       v = 16'd0;
      1:       v = 16'hFFFF;
      2:       v = 16'd4096;
      3, 4:    v = 16'($urandom_range(8191));
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // output side: random backpressure
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // output beat check against the oldest pending frame
  always @(posedge clk_i) begin
    mix_frame_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (mix_expected.size() == 0) begin
        report_mismatch("unexpected beat left", out_if.left_out, 16'sd0);
      end else begin
        want = mix_expected.pop_front();
        if (out_if.left_out !== want.left) begin
          report_mismatch("left_out", out_if.left_out, want.left);
        end
        if (out_if.right_out !== want.right) begin
          report_mismatch("right_out", out_if.right_out, want.right);
        end
      end
    end
  end

  // stimulus
  initial begin
    int unsigned n_items;
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CFG_ECHO_DELAY;
    cfg_wdata          = '0;
    in_if.valid        = 1'b0;
    in_if.left_sample  = '0;
    in_if.right_sample = '0;
    err_count          = 0;
    send_idle_pct      = 38;
    recv_idle_pct      = 64;
    line_wr_pos        = 0;
    echo_delay_q       = DELAY_RESET;
    echo_gain_q        = GAIN_RESET;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      left_line[i]  = '0;
      right_line[i] = '0;
    end

    // reset defaults, saturation, zero delay, truncation, out-of-line delays
    dir_rows = '{
      '{1'b0, 16'd0, 16'd0, 16'sh7FFF, 16'sh8000, 1'b1, 16'sh7FFF, 16'sh8000},
      '{1'b0, 16'd0, 16'd0, 16'sh7FFF, 16'sh8000, 1'b1, 16'sh7FFF, 16'sh8000},
      '{1'b0, 16'd0, 16'd0, 16'sd0, 16'sd0, 1'b1, 16'sh7FFF, 16'sh8000},
      '{1'b0, 16'd0, 16'd0, -16'sd1, 16'sd1, 1'b1, -16'sd1, 16'sd1},
      '{1'b0, 16'd0, 16'd0, 16'sd0, 16'sd0, 1'b1, -16'sd1, 16'sd1},
      '{1'b1, 16'd0, 16'd0, 16'sd1234, -16'sd1234, 1'b1, 16'sd1234, -16'sd1234},
      '{1'b1, 16'd0, 16'hFFFF, 16'sd1, -16'sd1, 1'b1, 16'sd16, -16'sd16},
      '{1'b0, 16'd0, 16'd0, 16'sh8000, 16'sh7FFF, 1'b1, 16'sh8000, 16'sh7FFF},
      '{1'b1, 16'd0, 16'd2048, -16'sd3, 16'sd3, 1'b1, -16'sd4, 16'sd4},
      '{1'b1, 16'(HIST_DEPTH - 1), 16'd4096, 16'sd100, 16'sd200, 1'b0, 16'sd0, 16'sd0},
      '{1'b0, 16'd0, 16'd0, -16'sd7, 16'sd9, 1'b0, 16'sd0, 16'sd0},
      '{1'b1, 16'(HIST_DEPTH), 16'd4096, 16'sd5000, -16'sd5000, 1'b1, 16'sd5000, -16'sd5000},
      '{1'b1, 16'hFFFF, 16'hFFFF, 16'sh8000, 16'sh7FFF, 1'b1, 16'sh8000, 16'sh7FFF},
      '{1'b1, 16'd2, 16'd3000, 16'sd12345, -16'sd12345, 1'b0, 16'sd0, 16'sd0},
      '{1'b0, 16'd0, 16'd0, -16'sd20000, 16'sd20000, 1'b0, 16'sd0, 16'sd0},
      '{1'b0, 16'd0, 16'd0, 16'sh7FFF, 16'sh8000, 1'b0, 16'sd0, 16'sd0}
    };

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part
    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_cfg) begin
        drain_pipe();
        write_reg(CFG_ECHO_DELAY, dir_rows[i].delay);
        write_reg(CFG_ECHO_GAIN, dir_rows[i].gain);
      end
      send_frame(dir_rows[i].left, dir_rows[i].right, dir_rows[i].known,
                 dir_rows[i].want_left, dir_rows[i].want_right);
    end

    // random part: three idling profiles, several settings each
    for (int epoch = 0; epoch < 3; epoch++) begin
      for (int ph = 0; ph < 6; ph++) begin
        drain_pipe();
        case (epoch)
          0: begin
            send_idle_pct = 38;
            recv_idle_pct = 64;
          end
          1: begin
            send_idle_pct = 64;
            recv_idle_pct = 38;
          end
          default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
          end
        endcase
        write_reg(CFG_ECHO_DELAY, rand_delay());
        write_reg(CFG_ECHO_GAIN, rand_gain());
        n_items = $urandom_range(110, 60);
        for (int k = 0; k < n_items; k++) begin
          send_frame(rand_sample(), rand_sample(), 1'b0, 16'sd0, 16'sd0);
        end
      end
    end

    in_if.valid <= 1'b0;
    while (mix_expected.size() != 0) @(negedge clk_i);
    repeat (16) @(posedge clk_i);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
